[src/rms_pkg.sv]
`default_nettype none

package rms_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_FRAME   = 4096;
   localparam int DEF_SAMPLE_BITS = 16;

   // Sum of squares and fixed result field widths
   localparam int SUM_W     = 43;
   localparam int RMS_W     = 16;
   localparam int CNT_OUT_W = 13;

   // Square root operates on an even number of radicand bits, two per step
   localparam int SQ_W       = SUM_W + (SUM_W % 2);
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int ROOT_W     = SQRT_STEPS;
   localparam int REM_W      = ROOT_W + 2;

   // Shared step counter for divide (SUM_W steps) and root (SQRT_STEPS steps)
   localparam int STEP_W = $clog2(SUM_W);

   // Frame-summary queue between the front and back ends
   localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

[src/rms_front.sv]
`default_nettype none

module rms_front #(
   parameter int MAX_FRAME   = rms_pkg::DEF_MAX_FRAME,
   parameter int SAMPLE_BITS = rms_pkg::DEF_SAMPLE_BITS,
   parameter int TALLY_W     = $clog2(MAX_FRAME + 1),
   parameter int ENTRY_W     = rms_pkg::SUM_W + TALLY_W + 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                   req_frame_last,
   output logic                        push,
   output logic [ENTRY_W-1:0]          push_data,
   input  wire logic                   queue_full
);

   localparam int SUM_W = rms_pkg::SUM_W;
   localparam int SQR_W = 2 * SAMPLE_BITS;

   logic [SAMPLE_BITS-1:0] mag;
   logic [SQR_W-1:0]       sq_ff, sq_in;
   logic                   last_ff;
   logic                   a_valid_ff;
   logic                   b_advance;

   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [TALLY_W-1:0]     tally_ff, tally_in;
   logic                   ovf_ff, ovf_in;
   logic                   room;

   // Square stage: magnitude of the two's complement sample, then square
   always_comb begin
      mag   = req_sample[SAMPLE_BITS-1] ? (~req_sample + SAMPLE_BITS'(1)) : req_sample;
      sq_in = SQR_W'(mag) * SQR_W'(mag);
   end

   // Hold the square stage only when a closing sample meets a full queue
   assign b_advance = a_valid_ff & ~(last_ff & queue_full);
   assign req_stall = a_valid_ff & last_ff & queue_full;

   // Accumulate stage
   always_comb begin
      room     = tally_ff < TALLY_W'(MAX_FRAME);
      sum_in   = room ? (sum_ff + SUM_W'(sq_ff)) : sum_ff;
      tally_in = room ? (tally_ff + TALLY_W'(1)) : tally_ff;
      ovf_in   = ovf_ff | ~room;
   end

   assign push      = b_advance & last_ff;
   assign push_data = {sum_in, tally_in, ovf_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         sq_ff   <= sq_in;
         last_ff <= req_frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         tally_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (b_advance) begin
         if (last_ff) begin
            sum_ff   <= '0;
            tally_ff <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            sum_ff   <= sum_in;
            tally_ff <= tally_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   tally_bound_a : assert property (@(posedge clock) disable iff (reset)
      tally_ff <= TALLY_W'(MAX_FRAME))
      else $error("sample tally ran past the frame limit");

   ovf_full_a : assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> tally_ff == TALLY_W'(MAX_FRAME))
      else $error("overflow flagged before the frame was full");

endmodule

`default_nettype wire

[src/rms_fifo.sv]
`default_nettype none

module rms_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = rms_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  full,
   output logic                  not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] queue_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   no_overrun_a : assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("write into a full frame queue");

   no_underrun_a : assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("read from an empty frame queue");

endmodule

`default_nettype wire

[src/rms_back.sv]
`default_nettype none

module rms_back #(
   parameter int TALLY_W = 13,
   parameter int ENTRY_W = rms_pkg::SUM_W + TALLY_W + 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_valid,
   output logic                                pop,
   input  wire logic [ENTRY_W-1:0]             q_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [rms_pkg::RMS_W-1:0]           rsp_rms_level,
   output logic [rms_pkg::CNT_OUT_W-1:0]       rsp_frame_samples,
   output logic                                rsp_frame_overflow
);

   localparam int SUM_W      = rms_pkg::SUM_W;
   localparam int SQ_W       = rms_pkg::SQ_W;
   localparam int ROOT_W     = rms_pkg::ROOT_W;
   localparam int REM_W      = rms_pkg::REM_W;
   localparam int STEP_W     = rms_pkg::STEP_W;
   localparam int RMS_W      = rms_pkg::RMS_W;
   localparam int CNT_OUT_W  = rms_pkg::CNT_OUT_W;
   localparam int SQRT_STEPS = rms_pkg::SQRT_STEPS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_ROOT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   // Divider: dividend shifts out of quo_ff as quotient bits shift in
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [TALLY_W:0]    rem_ff, rem_in, rem_sh;
   logic [TALLY_W-1:0]  div_ff, div_in;
   logic                ovf_ff, ovf_in;
   logic                div_ge;

   // Root: two radicand bits per step
   logic [SQ_W-1:0]     rad_ff, rad_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [REM_W-1:0]    srem_ff, srem_in, srem_sh, trial;
   logic                root_ge;

   logic                out_load;
   logic                rsp_valid_ff;
   logic [RMS_W-1:0]    rms_ff;
   logic [CNT_OUT_W-1:0] cnt_ff;
   logic                oflag_ff;

   always_comb begin
      rem_sh  = {rem_ff[TALLY_W-1:0], quo_ff[SUM_W-1]};
      div_ge  = rem_sh >= {1'b0, div_ff};
      srem_sh = {srem_ff[REM_W-3:0], rad_ff[SQ_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      root_ge = srem_sh >= trial;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      ovf_in   = ovf_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      srem_in  = srem_ff;
      pop      = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               quo_in   = q_data[ENTRY_W-1 -: SUM_W];
               div_in   = q_data[TALLY_W:1];
               ovf_in   = q_data[0];
               rem_in   = '0;
               step_in  = STEP_W'(SUM_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = div_ge ? (rem_sh - {1'b0, div_ff}) : rem_sh;
            quo_in  = {quo_ff[SUM_W-2:0], div_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               // Zero count yields a zero mean
               rad_in   = (div_ff == '0) ? '0 : SQ_W'(quo_in);
               root_in  = '0;
               srem_in  = '0;
               step_in  = STEP_W'(SQRT_STEPS - 1);
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            srem_in = root_ge ? (srem_sh - trial) : srem_sh;
            root_in = {root_ff[ROOT_W-2:0], root_ge};
            rad_in  = {rad_ff[SQ_W-3:0], 2'b00};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      ovf_ff  <= ovf_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rms_ff   <= root_ff[RMS_W-1:0];
         cnt_ff   <= CNT_OUT_W'(div_ff);
         oflag_ff <= ovf_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rms_level      = rms_ff;
   assign rsp_frame_samples  = cnt_ff;
   assign rsp_frame_overflow = oflag_ff;

   result_from_done_a : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the done step");

endmodule

`default_nettype wire

[src/frame_rms_level.sv]
// Frame RMS level: floor(sqrt(floor(sum of squares / count))) per frame.
// Throughput: one sample per cycle while req_stall is low. The back end finishes a frame (pop,
// 43 divide steps, 22 root steps, result load) before it pops the next one; a closing sample
// stalls only on a full queue. From the closing sample transfer to rsp_valid, with an idle back
// end, the path runs: square stage, queue push, pop, bit-serial divide, root, result register.
// Reset (synchronous, active high) clears the accumulator, count, queue and result valid flag.
`default_nettype none

module frame_rms_level #(
   parameter int MAX_FRAME   = rms_pkg::DEF_MAX_FRAME,
   parameter int SAMPLE_BITS = rms_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Sample channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [SAMPLE_BITS-1:0]        req_sample,
   input  wire logic                          req_frame_last,
   // Result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [rms_pkg::RMS_W-1:0]          rsp_rms_level,
   output logic [rms_pkg::CNT_OUT_W-1:0]      rsp_frame_samples,
   output logic                               rsp_frame_overflow
);

   // Tally must reach MAX_FRAME itself
   localparam int TALLY_W = $clog2(MAX_FRAME + 1);
   // One queue entry: frame sum of squares, sample count, overflow flag
   localparam int ENTRY_W = rms_pkg::SUM_W + TALLY_W + 1;

   logic               push;
   logic [ENTRY_W-1:0] push_data;
   logic               pop;
   logic [ENTRY_W-1:0] pop_data;
   logic               queue_full;
   logic               queue_valid;

   // Front end: square each sample and accumulate it; a closing sample
   // pushes the finished frame summary and clears the accumulator. It
   // stalls the sample channel only when a closing sample meets a full queue.
   rms_front #(
      .MAX_FRAME   (MAX_FRAME),
      .SAMPLE_BITS (SAMPLE_BITS),
      .TALLY_W     (TALLY_W),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_frame_last (req_frame_last),
      .push           (push),
      .push_data      (push_data),
      .queue_full     (queue_full)
   );

   // Frame summaries wait here so sampling keeps going while the back end
   // works on an earlier frame.
   rms_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (rms_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .not_empty (queue_valid)
   );

   // Back end: divide by the count one quotient bit per cycle, take the
   // root two radicand bits per cycle, then load the result register.
   rms_back #(
      .TALLY_W (TALLY_W),
      .ENTRY_W (ENTRY_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (queue_valid),
      .pop                (pop),
      .q_data             (pop_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rms_level      (rsp_rms_level),
      .rsp_frame_samples  (rsp_frame_samples),
      .rsp_frame_overflow (rsp_frame_overflow)
   );

endmodule

`default_nettype wire
